### design/disparity_hsv_colorizer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the disparity HSV colorizer core
// Same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_HSV_COLORIZER_CORE_ASSERT_SVH
`define DISPARITY_HSV_COLORIZER_CORE_ASSERT_SVH

// pre implies post in the same cycle
`define DHC_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// pre implies post in the next cycle
`define DHC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### design/dhc_pkg.sv
// ----------------------------------------------------------------------------
// dhc_pkg
// Shared types, constants and the sector table of the disparity colorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dhc_pkg;

   localparam int DISP_W      = 8;
   localparam int Q8_W        = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int CHAN_W      = 8;
   localparam int LANES       = 3;

   localparam int HUE_SPAN     = 240;
   localparam int SECTOR_WIDTH = 60;
   localparam int Q_ONE        = 256;
   localparam int COEF_ONE     = SECTOR_WIDTH * Q_ONE;
   localparam int DENOM        = SECTOR_WIDTH * Q_ONE * Q_ONE;
   localparam int FULL_SCALE   = 255;
   localparam int RECIP_SHIFT  = 20;
   localparam int RECIP_60     = ((1 << RECIP_SHIFT) + SECTOR_WIDTH - 1) / SECTOR_WIDTH;
   localparam int DIV_STEPS    = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED_MAX  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SATURATION = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS = 2'd2;

   localparam logic [DISP_W-1:0] FIXED_MAX_RESET  = 8'd0;
   localparam logic [Q8_W-1:0]   SATURATION_RESET = 9'd256;
   localparam logic [Q8_W-1:0]   BRIGHTNESS_RESET = 9'd256;

   localparam logic [1:0] LANE_BLUE  = 2'd0;
   localparam logic [1:0] LANE_GREEN = 2'd1;
   localparam logic [1:0] LANE_RED   = 2'd2;

   localparam logic [0:0] CMD_MEASURE  = 1'b0;
   localparam logic [0:0] CMD_COLORIZE = 1'b1;

   typedef enum logic [1:0] {
      TERM_V,
      TERM_P,
      TERM_Q,
      TERM_T
   } term_type;

   typedef struct packed {
      logic              zero;
      logic [DISP_W-1:0] m;
      logic [DISP_W-1:0] d;
   } job_type;

   typedef struct packed {
      logic [Q8_W-1:0] sat;
      logic [Q8_W-1:0] bri;
   } cfg_type;

   function automatic term_type sector_term(input logic [2:0] hi, input logic [1:0] lane);
      term_type b;
      term_type g;
      term_type r;
      case (hi)
         3'd0: begin b = TERM_P; g = TERM_T; r = TERM_V; end
         3'd1: begin b = TERM_P; g = TERM_V; r = TERM_Q; end
         3'd2: begin b = TERM_T; g = TERM_V; r = TERM_P; end
         3'd3: begin b = TERM_V; g = TERM_Q; r = TERM_P; end
         3'd4: begin b = TERM_V; g = TERM_P; r = TERM_T; end
         default: begin b = TERM_Q; g = TERM_P; r = TERM_V; end
      endcase
      case (lane)
         LANE_BLUE:  sector_term = b;
         LANE_GREEN: sector_term = g;
         default:    sector_term = r;
      endcase
   endfunction

endpackage

`default_nettype wire

### design/disparity_hsv_colorizer_core.sv
// ----------------------------------------------------------------------------
// disparity_hsv_colorizer_core
// Maps 8-bit disparity pixels to false-color BGR pixels through HSV.
// ----------------------------------------------------------------------------
// Measure items (tuser bit 0 low) are taken one per cycle unless the queue is
// full, and update the frame maximum; they produce no result. A colorize item
// occupies the back end through queue pop, an 8-step restoring hue divider,
// sector decode, four registered multiply stages and the result register; a
// zero effective maximum gives black via the result register. The two-entry
// queue lets the front keep taking items while the back works, and ready drops
// only when it is full. Configuration writes are always taken (csr_ready high).
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_hsv_colorizer_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [dhc_pkg::DISP_W-1:0]           req_tdata,  // disparity
   input  wire logic [1:0]                           req_tuser,  // command, frame_start
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [dhc_pkg::LANES*dhc_pkg::CHAN_W-1:0] rsp_tdata,  // blue, green, red
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [dhc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [dhc_pkg::CSR_DATA_W-1:0]       csr_data
);

   logic [dhc_pkg::DISP_W-1:0] fixed_max_ff;
   logic [dhc_pkg::Q8_W-1:0]   sat_ff;
   logic [dhc_pkg::Q8_W-1:0]   bri_ff;
   dhc_pkg::cfg_type           cfg;
   logic                       push;
   dhc_pkg::job_type           push_job;
   logic                       queue_full;
   logic                       pop;
   logic                       head_valid;
   dhc_pkg::job_type           head_job;

   assign csr_ready = 1'b1;
   assign cfg.sat   = sat_ff;
   assign cfg.bri   = bri_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_max_ff <= dhc_pkg::FIXED_MAX_RESET;
         sat_ff       <= dhc_pkg::SATURATION_RESET;
         bri_ff       <= dhc_pkg::BRIGHTNESS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dhc_pkg::CSR_FIXED_MAX:  fixed_max_ff <= csr_data[dhc_pkg::DISP_W-1:0];
            dhc_pkg::CSR_SATURATION: sat_ff       <= csr_data;
            dhc_pkg::CSR_BRIGHTNESS: bri_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   dhc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fixed_max  (fixed_max_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   dhc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   dhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

### design/dhc_front.sv
// ----------------------------------------------------------------------------
// dhc_front
// Accepts pixels, folds measure items into the frame maximum and queues
// colorize items with their effective maximum and clamped disparity.
// ----------------------------------------------------------------------------
`default_nettype none

module dhc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [dhc_pkg::DISP_W-1:0]    req_tdata,   // disparity
   input  wire logic [1:0]                    req_tuser,   // command, frame_start
   input  wire logic [dhc_pkg::DISP_W-1:0]    fixed_max,
   input  wire logic                          queue_full,
   output logic                               push,
   output dhc_pkg::job_type                   push_job
);

   logic                       accept;
   logic [dhc_pkg::DISP_W-1:0] max_ff;
   logic [dhc_pkg::DISP_W-1:0] max_in;
   logic [dhc_pkg::DISP_W-1:0] base;
   logic [dhc_pkg::DISP_W-1:0] m;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      base   = req_tuser[1] ? '0 : max_ff;
      max_in = max_ff;
      if (accept && (req_tuser[0] == dhc_pkg::CMD_MEASURE)) begin
         max_in = (req_tdata > base) ? req_tdata : base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else begin
         max_ff <= max_in;
      end
   end

   always_comb begin
      m             = (fixed_max != '0) ? fixed_max : max_ff;
      push          = accept && (req_tuser[0] == dhc_pkg::CMD_COLORIZE);
      push_job.zero = (m == '0);
      push_job.m    = m;
      push_job.d    = (req_tdata > m) ? m : req_tdata;
   end

endmodule

`default_nettype wire

### design/dhc_queue.sv
// ----------------------------------------------------------------------------
// dhc_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dhc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dhc_pkg::job_type push_job,
   input  wire logic             pop,
   output logic                  full,
   output logic                  head_valid,
   output dhc_pkg::job_type      head_job
);

   dhc_pkg::job_type                 mem_ff [dhc_pkg::QUEUE_DEPTH];
   logic [dhc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [dhc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_in;
   logic [dhc_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [dhc_pkg::QUEUE_PTR_W-1:0]  rd_ptr_in;
   logic [dhc_pkg::QUEUE_CNT_W-1:0]  count_ff;
   logic [dhc_pkg::QUEUE_CNT_W-1:0]  count_in;
   logic                             do_pop;

   assign full       = (count_ff == dhc_pkg::QUEUE_CNT_W'(dhc_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### design/dhc_back.sv
// ----------------------------------------------------------------------------
// dhc_back
// Hue divider, sector decode and three-lane HSV-to-BGR arithmetic with the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "disparity_hsv_colorizer_core_assert.svh"

module dhc_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              head_valid,
   input  wire dhc_pkg::job_type                  head_job,
   output logic                                   pop,
   input  wire dhc_pkg::cfg_type                  cfg,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [dhc_pkg::LANES*dhc_pkg::CHAN_W-1:0] rsp_tdata  // blue, green, red
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DIV   = 8'b0000_0010,
      ST_SECT  = 8'b0000_0100,
      ST_COEF  = 8'b0000_1000,
      ST_PROD  = 8'b0001_0000,
      ST_SCALE = 8'b0010_0000,
      ST_FIN   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } back_state_type;

   localparam int CNT_W = $clog2(dhc_pkg::DIV_STEPS);

   back_state_type              state_ff;
   back_state_type              state_in;
   dhc_pkg::job_type            job_ff;
   logic [dhc_pkg::DISP_W-1:0]  rem_ff;
   logic [dhc_pkg::DISP_W-1:0]  rem_in;
   logic [dhc_pkg::DISP_W-1:0]  quo_ff;
   logic [dhc_pkg::DISP_W-1:0]  quo_in;
   logic [CNT_W-1:0]            cnt_ff;
   logic [CNT_W-1:0]            cnt_in;
   logic [2:0]                  hi_ff;
   logic [2:0]                  hi_in;
   logic [5:0]                  r_ff;
   logic [5:0]                  r_in;
   logic signed [15:0]          coef_ff [dhc_pkg::LANES];
   logic signed [15:0]          coef_in [dhc_pkg::LANES];
   logic signed [24:0]          prod_ff [dhc_pkg::LANES];
   logic signed [24:0]          prod_in [dhc_pkg::LANES];
   logic [13:0]                 y_ff    [dhc_pkg::LANES];
   logic [13:0]                 y_in    [dhc_pkg::LANES];
   logic [dhc_pkg::CHAN_W-1:0]  chan_ff [dhc_pkg::LANES];
   logic [dhc_pkg::CHAN_W-1:0]  chan_in [dhc_pkg::LANES];
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [dhc_pkg::LANES*dhc_pkg::CHAN_W-1:0] rsp_data_ff;
   logic                        out_free;
   logic [dhc_pkg::DISP_W-1:0]  diff;
   logic [15:0]                 num;
   logic [dhc_pkg::DISP_W:0]    trial;
   logic                        qbit;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pop        = (state_ff == ST_IDLE) && head_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // hue numerator and one restoring divide step
   always_comb begin
      diff  = head_job.m - head_job.d;
      num   = 16'(diff) * 16'(dhc_pkg::HUE_SPAN);
      trial = {rem_ff, quo_ff[dhc_pkg::DISP_W-1]};
      qbit  = (trial >= {1'b0, job_ff.m});
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               state_in = head_job.zero ? ST_OUT : ST_DIV;
               cnt_in   = CNT_W'(dhc_pkg::DIV_STEPS - 1);
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SECT;
            end
         end
         ST_SECT:  state_in = ST_COEF;
         ST_COEF:  state_in = ST_PROD;
         ST_PROD:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_FIN;
         ST_FIN:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (state_ff == ST_IDLE) begin
         rem_in = num[15:8];
         quo_in = num[7:0];
      end else if (state_ff == ST_DIV) begin
         rem_in = qbit ? dhc_pkg::DISP_W'(trial - {1'b0, job_ff.m})
                       : trial[dhc_pkg::DISP_W-1:0];
         quo_in = {quo_ff[dhc_pkg::DISP_W-2:0], qbit};
      end
   end

   always_comb begin
      if (quo_ff >= 8'd240) begin
         hi_in = 3'd4;
         r_in  = 6'(quo_ff - 8'd240);
      end else if (quo_ff >= 8'd180) begin
         hi_in = 3'd3;
         r_in  = 6'(quo_ff - 8'd180);
      end else if (quo_ff >= 8'd120) begin
         hi_in = 3'd2;
         r_in  = 6'(quo_ff - 8'd120);
      end else if (quo_ff >= 8'd60) begin
         hi_in = 3'd1;
         r_in  = 6'(quo_ff - 8'd60);
      end else begin
         hi_in = 3'd0;
         r_in  = quo_ff[5:0];
      end
   end

   always_comb begin
      logic [5:0]         k;
      logic [14:0]        ks;
      logic signed [25:0] p;
      logic [21:0]        cl;
      logic [29:0]        sc;
      logic [28:0]        f;
      for (int i = 0; i < dhc_pkg::LANES; i++) begin
         case (dhc_pkg::sector_term(hi_ff, 2'(i)))
            dhc_pkg::TERM_V: k = 6'd0;
            dhc_pkg::TERM_P: k = 6'(dhc_pkg::SECTOR_WIDTH);
            dhc_pkg::TERM_Q: k = r_ff;
            default:         k = 6'(dhc_pkg::SECTOR_WIDTH) - r_ff;
         endcase
         ks         = 15'(k) * 15'(cfg.sat);
         coef_in[i] = $signed(16'(dhc_pkg::COEF_ONE) - 16'(ks));

         p          = $signed({1'b0, cfg.bri}) * coef_ff[i];
         prod_in[i] = p[24:0];

         if (prod_ff[i] < 25'sd0) begin
            cl = '0;
         end else if (prod_ff[i] > $signed(25'(dhc_pkg::DENOM))) begin
            cl = 22'(dhc_pkg::DENOM);
         end else begin
            cl = prod_ff[i][21:0];
         end
         sc      = 30'(cl) * 30'(dhc_pkg::FULL_SCALE);
         y_in[i] = sc[29:16];

         f = 29'(y_ff[i]) * 29'(dhc_pkg::RECIP_60);
         if (state_ff == ST_IDLE) begin
            chan_in[i] = '0;
         end else if (state_ff == ST_FIN) begin
            chan_in[i] = f[dhc_pkg::RECIP_SHIFT+dhc_pkg::CHAN_W-1:dhc_pkg::RECIP_SHIFT];
         end else begin
            chan_in[i] = chan_ff[i];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (state_ff == ST_SECT) begin
         hi_ff <= hi_in;
         r_ff  <= r_in;
      end
      for (int i = 0; i < dhc_pkg::LANES; i++) begin
         if (state_ff == ST_COEF) begin
            coef_ff[i] <= coef_in[i];
         end
         if (state_ff == ST_PROD) begin
            prod_ff[i] <= prod_in[i];
         end
         if (state_ff == ST_SCALE) begin
            y_ff[i] <= y_in[i];
         end
         chan_ff[i] <= chan_in[i];
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_data_ff <= {chan_ff[2], chan_ff[1], chan_ff[0]};
      end
   end

   `DHC_ASSERT_IMPL(a_div_nonzero, clock, reset, state_ff == ST_DIV, job_ff.m != '0, "divide by zero maximum")
   `DHC_ASSERT_IMPL(a_rem_bound, clock, reset, state_ff == ST_DIV, rem_ff < job_ff.m, "remainder not below divisor")
   `DHC_ASSERT_NEXT(a_out_load, clock, reset, (state_ff == ST_OUT) && out_free, rsp_valid_ff && (state_ff == ST_IDLE), "result not loaded")

endmodule

`default_nettype wire

### tb/tb_disparity_hsv_colorizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disparity_hsv_colorizer_core
// Drives measure and colorize pixel streams through the colorizer under a
// series of max, saturation and value settings with random gaps on both
// streams. An independent HSV predictor tracks the frame maximum and the
// register file, works out each BGR pixel, and checks every result in order.
// ----------------------------------------------------------------------------

module tb_disparity_hsv_colorizer_core;

   import dhc_pkg::*;

   localparam int RUN_LIMIT    = 600000;
   localparam int SETTLE       = 24;
   localparam int REPORT_CAP   = 60;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 98;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } bgr_pixel_type;

   class bgr_tracker;
      logic [DISP_W-1:0] fixed_max;
      logic [Q8_W-1:0]   sat;
      logic [Q8_W-1:0]   bri;
      logic [DISP_W-1:0] frame_max;
      bgr_pixel_type     owed_pixels[$];
      int                errors;

      function new();
         fixed_max = FIXED_MAX_RESET;
         sat       = SATURATION_RESET;
         bri       = BRIGHTNESS_RESET;
         frame_max = '0;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FIXED_MAX:  fixed_max = data[DISP_W-1:0];
            CSR_SATURATION: sat = data[Q8_W-1:0];
            CSR_BRIGHTNESS: bri = data[Q8_W-1:0];
            default: ;
         endcase
      endfunction

      function longint channel_level(longint num);
         longint n;
         n = num;
         if (n < 0) n = 0;
         if (n > longint'(DENOM)) n = DENOM;
         return (n * FULL_SCALE) / DENOM;
      endfunction

      function bgr_pixel_type hsv_pixel(int top, int disp);
         int            dd;
         int            hue;
         int            frac;
         longint        s;
         longint        v;
         longint        vv;
         longint        pv;
         longint        qv;
         longint        tv;
         longint        b;
         longint        g;
         longint        r;
         bgr_pixel_type px;
         px = '0;
         if (top < 1) return px;
         dd   = (disp > top) ? top : disp;
         hue  = ((top - dd) * HUE_SPAN) / top;
         frac = hue % SECTOR_WIDTH;
         s  = longint'(sat);
         v  = longint'(bri);
         vv = v * COEF_ONE;
         pv = v * (COEF_ONE - SECTOR_WIDTH * s);
         qv = v * (COEF_ONE - frac * s);
         tv = v * (COEF_ONE - (SECTOR_WIDTH - frac) * s);
         case (hue / SECTOR_WIDTH)
            0: begin b = pv; g = tv; r = vv; end
            1: begin b = pv; g = vv; r = qv; end
            2: begin b = tv; g = vv; r = pv; end
            3: begin b = vv; g = qv; r = pv; end
            4: begin b = vv; g = pv; r = tv; end
            default: begin b = qv; g = pv; r = vv; end
         endcase
         px.blue  = CHAN_W'(channel_level(b));
         px.green = CHAN_W'(channel_level(g));
         px.red   = CHAN_W'(channel_level(r));
         return px;
      endfunction

      function void take_item(logic [1:0] kind, logic [DISP_W-1:0] disp);
         int top;
         if (kind[0] == CMD_MEASURE) begin
            if (kind[1]) frame_max = '0;
            if (disp > frame_max) frame_max = disp;
         end else begin
            top = (fixed_max != 0) ? int'(fixed_max) : int'(frame_max);
            owed_pixels.insert(owed_pixels.size(), hsv_pixel(top, int'(disp)));
         end
      endfunction

      function void report(string field, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
         errors++;
         if (errors <= REPORT_CAP)
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void match_pixel(bgr_pixel_type got);
         bgr_pixel_type want;
         if (owed_pixels.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t unexpected pixel: expected none, actual %h", $time, got);
            return;
         end
         want = owed_pixels.pop_front();
         if (got.blue !== want.blue) report("blue", want.blue, got.blue);
         if (got.green !== want.green) report("green", want.green, got.green);
         if (got.red !== want.red) report("red", want.red, got.red);
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [DISP_W-1:0]           req_tdata = '0;
   logic [1:0]                  req_tuser = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [LANES*CHAN_W-1:0]     rsp_tdata;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   int unsigned cycle_count = 0;
   int          req_gap = 0;
   bit          req_live = 1'b0;
   int          send_pace = 0;
   int          take_pace = 0;
   bgr_tracker  sb = new();

   disparity_hsv_colorizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.take_item(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.match_pixel(rsp_tdata);
      if (!reset && csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
   end

   function automatic int draw_gap(int pace);
      case (pace)
         0: return 0;
         1: return $urandom_range(0, 19);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
      endcase
   endfunction

   task automatic send_item(logic [0:0] cmd, logic frame_start, logic [DISP_W-1:0] disp);
      if (req_gap > 0) repeat (req_gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= {frame_start, cmd};
      req_tdata  <= disp;
      do @(posedge clock); while (!req_tready);
      req_gap = draw_gap(send_pace);
      if (req_gap > 0) req_tvalid <= 1'b0;
      req_live = (req_gap == 0);
   endtask

   // hold the input until every pending pixel is out
   task automatic drain_pixels();
      if (req_live) req_tvalid <= 1'b0;
      req_live = 1'b0;
      req_gap  = 0;
      @(posedge clock);
      while (sb.owed_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(logic [CSR_DATA_W-1:0] top, logic [CSR_DATA_W-1:0] s,
                                logic [CSR_DATA_W-1:0] v);
      drain_pixels();
      repeat (SETTLE) @(posedge clock);
      if ($urandom_range(0, 2) == 0) write_reg(CSR_SPARE, 9'($urandom_range(0, 511)));
      write_reg(CSR_FIXED_MAX, top);
      write_reg(CSR_SATURATION, s);
      write_reg(CSR_BRIGHTNESS, v);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int count);
      int sent;
      int n;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
               send_item(CMD_MEASURE, (i == 0) || ($urandom_range(0, 15) == 0),
                         ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
            end
            sent += n;
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
               send_item(CMD_COLORIZE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            sent += n;
         end else begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
               send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
            end
            sent += n;
         end
         if ($urandom_range(0, 24) == 0) drain_pixels();
      end
   endtask

   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = draw_gap(take_pace);
         if ($urandom_range(0, 39) == 0) take_pace = $urandom_range(0, 2);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      wait (cycle_count == RUN_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [CSR_DATA_W-1:0] tops[6] = '{9'd0, 9'd255, 9'd1, 9'd0, 9'd0, 9'd511};
      logic [CSR_DATA_W-1:0] sats[6] = '{9'd256, 9'd0, 9'd256, 9'd511, 9'd0, 9'd128};
      logic [CSR_DATA_W-1:0] vals[6] = '{9'd256, 9'd256, 9'd0, 9'd511, 9'd0, 9'd300};
      logic [CSR_DATA_W-1:0] top;
      logic [CSR_DATA_W-1:0] s;
      logic [CSR_DATA_W-1:0] v;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: measured maximum, full saturation and value
      send_item(CMD_COLORIZE, 1'b0, 8'd77);
      send_item(CMD_MEASURE, 1'b1, 8'd0);
      send_item(CMD_COLORIZE, 1'b0, 8'd0);
      send_item(CMD_MEASURE, 1'b0, 8'd255);
      send_item(CMD_MEASURE, 1'b0, 8'd3);
      send_item(CMD_COLORIZE, 1'b0, 8'd255);
      send_item(CMD_COLORIZE, 1'b0, 8'd0);
      send_item(CMD_COLORIZE, 1'b0, 8'd180);
      send_item(CMD_COLORIZE, 1'b0, 8'd100);
      send_item(CMD_COLORIZE, 1'b0, 8'd40);
      send_item(CMD_COLORIZE, 1'b1, 8'd50);
      send_item(CMD_COLORIZE, 1'b0, 8'd200);
      send_item(CMD_MEASURE, 1'b1, 8'd100);
      send_item(CMD_COLORIZE, 1'b0, 8'd250);
      send_item(CMD_COLORIZE, 1'b0, 8'd100);
      send_item(CMD_COLORIZE, 1'b0, 8'd1);
      send_item(CMD_MEASURE, 1'b1, 8'd170);
      send_item(CMD_MEASURE, 1'b0, 8'd85);
      send_item(CMD_COLORIZE, 1'b1, 8'd128);
      send_item(CMD_COLORIZE, 1'b0, 8'd85);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 6) begin
            top = tops[ph];
            s   = sats[ph];
            v   = vals[ph];
         end else begin
            top = ($urandom_range(0, 2) == 0) ? 9'd0 : 9'($urandom_range(0, 511));
            s   = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(257, 511))
                                              : 9'($urandom_range(0, 256));
            v   = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(257, 511))
                                              : 9'($urandom_range(0, 256));
         end
         load_settings(top, s, v);
         send_pace = ph % 3;
         random_phase(PHASE_ITEMS);
      end

      drain_pixels();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.owed_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
